@@ rtl/hdnw_pkg.sv @@
// Package for the character LCD nibble writer: phase and action codes, init command table.
package hdnw_pkg;

  typedef enum logic [2:0] {
    PH_POWER   = 3'd0,
    PH_EN_HIGH = 3'd1,
    PH_GAP     = 3'd2,
    PH_CLEAR   = 3'd3,
    PH_IDLE    = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_CMD    = 2'd1,
    ACT_DATA   = 2'd2,
    ACT_CURSOR = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    REG_POWER_WAIT  = 2'd0,
    REG_ENABLE_HIGH = 2'd1,
    REG_NIBBLE_GAP  = 2'd2,
    REG_CLEAR_WAIT  = 2'd3
  } cfg_reg_e;

  localparam logic [2:0] INIT_COUNT    = 3'd6;
  localparam logic [7:0] CURSOR_CMD    = 8'h80;
  localparam logic [6:0] ROW1_BASE     = 7'h40;

  localparam logic [15:0] POWER_WAIT_RST  = 16'd40000;
  localparam logic [7:0]  ENABLE_HIGH_RST = 8'd1;
  localparam logic [9:0]  NIBBLE_GAP_RST  = 10'd50;
  localparam logic [15:0] CLEAR_WAIT_RST  = 16'd2000;

  // Init command sequence: function set (x3 wake-up), 4-bit mode, display on,
  // entry mode, clear.
  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h33;
      3'd1:    b = 8'h32;
      3'd2:    b = 8'h28;
      3'd3:    b = 8'h0C;
      3'd4:    b = 8'h06;
      3'd5:    b = 8'h01;
      default: b = 8'h01;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/hd44780_nibble_writer_top.sv @@
// Character LCD 4-bit write interface driver: tick/request stream in, pin states out.
//
//  Channel  | Dir | Handshake              | Payload
//  ---------+-----+------------------------+-------------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready   | tuser: action; tdata: value, row, col
//  m_axis   | out | m_axis_tvalid/tready   | tdata: rs, rw, en, data, busy, rejected
//  cfg      | in  | cfg_we_i (no ready)    | cfg_idx_i, cfg_data_i
//
// One transaction in gives one transaction out. Each item is handled as it is accepted:
// the state registers update at the accepting edge and the result is pushed
// into a two-entry output buffer, so a new item can be taken every cycle.
// s_axis_tready drops only when both output slots are full (sink stalled).
// Reset puts the block in the power-up wait with the countdown loaded from
// the power wait reset value; config registers return to their defaults.
module hd44780_nibble_writer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] value, [8] row, [14:9] col, [15] zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] action
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [0] pin_rs, [1] pin_rw, [2] pin_en,
                                     // [6:3] pin_data, [7] busy_res, [8] rejected
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import hdnw_pkg::*;

  localparam int unsigned ResW = 9;

  // config registers; the power wait only matters as a countdown reload
  logic [7:0]  enable_high_q;
  logic [9:0]  nibble_gap_q;
  logic [15:0] clear_wait_q;

  // controller state
  phase_e      phase_q, phase_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  byte_q, byte_d;
  logic        sel_q, sel_d;
  logic        lowpend_q, lowpend_d;
  logic [2:0]  init_idx_q, init_idx_d;
  logic        en_q, en_d;
  logic [3:0]  nib_q, nib_d;

  // output buffer: slot 0 is the head
  logic            v0_q, v1_q;
  logic [ResW-1:0] slot0_q, slot1_q;

  logic            s_fire, m_fire;
  action_e         action;
  logic [7:0]      in_value;
  logic            in_row;
  logic [5:0]      in_col;
  logic            cnt_done;
  logic            do_start, do_low;
  logic [7:0]      start_byte;
  logic            start_sel;
  logic            rej;
  logic [2:0]      idx_inc;
  logic [6:0]      cursor_addr;
  logic [ResW-1:0] res;

  assign action   = action_e'(s_axis_tuser);
  assign in_value = s_axis_tdata[7:0];
  assign in_row   = s_axis_tdata[8];
  assign in_col   = s_axis_tdata[14:9];

  assign s_axis_tready = !v1_q;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = v0_q && m_axis_tready;
  assign m_axis_tvalid = v0_q;
  assign m_axis_tdata  = {{(16 - ResW){1'b0}}, slot0_q};

  // a zero countdown behaves like one
  assign cnt_done    = (cnt_q <= 16'd1);
  assign idx_inc     = init_idx_q + 3'd1;
  assign cursor_addr = in_row ? (ROW1_BASE + {1'b0, in_col}) : {1'b0, in_col};

  // next-state logic for one item
  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    byte_d     = byte_q;
    sel_d      = sel_q;
    lowpend_d  = lowpend_q;
    init_idx_d = init_idx_q;
    en_d       = en_q;
    nib_d      = nib_q;
    do_start   = 1'b0;
    do_low     = 1'b0;
    start_byte = 8'h00;
    start_sel  = 1'b0;
    rej        = 1'b0;

    if (s_fire) begin
      if (action == ACT_TICK) begin
        case (phase_q)
          PH_POWER: begin
            if (cnt_done) begin
              init_idx_d = 3'd0;
              do_start   = 1'b1;
              start_byte = init_byte(3'd0);
            end else begin
              cnt_d = cnt_q - 16'd1;
            end
          end
          PH_EN_HIGH: begin
            if (cnt_done) begin
              en_d    = 1'b0;
              cnt_d   = {6'd0, nibble_gap_q};
              phase_d = PH_GAP;
            end else begin
              cnt_d = cnt_q - 16'd1;
            end
          end
          PH_GAP: begin
            if (!cnt_done) begin
              cnt_d = cnt_q - 16'd1;
            end else if (lowpend_q) begin
              do_low = 1'b1;
            end else if (init_idx_q < INIT_COUNT) begin
              // byte finished during init: next command or clear wait
              init_idx_d = idx_inc;
              if (idx_inc < INIT_COUNT) begin
                do_start   = 1'b1;
                start_byte = init_byte(idx_inc);
              end else if (clear_wait_q == 16'd0) begin
                phase_d = PH_IDLE;
              end else begin
                cnt_d   = clear_wait_q;
                phase_d = PH_CLEAR;
              end
            end else begin
              phase_d = PH_IDLE;
            end
          end
          PH_CLEAR: begin
            if (cnt_done) begin
              phase_d = PH_IDLE;
            end else begin
              cnt_d = cnt_q - 16'd1;
            end
          end
          default: ;
        endcase
      end else if (phase_q != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        do_start = 1'b1;
        case (action)
          ACT_CMD:  start_byte = in_value;
          ACT_DATA: begin
            start_byte = in_value;
            start_sel  = 1'b1;
          end
          default:  start_byte = CURSOR_CMD | {1'b0, cursor_addr};
        endcase
      end
    end

    if (do_start) begin
      byte_d    = start_byte;
      sel_d     = start_sel;
      lowpend_d = 1'b1;
      nib_d     = start_byte[7:4];
      en_d      = 1'b1;
      cnt_d     = {8'd0, enable_high_q};
      phase_d   = PH_EN_HIGH;
    end
    if (do_low) begin
      lowpend_d = 1'b0;
      nib_d     = byte_q[3:0];
      en_d      = 1'b1;
      cnt_d     = {8'd0, enable_high_q};
      phase_d   = PH_EN_HIGH;
    end

    // rewriting the power wait during power-up restarts the countdown
    if (cfg_we_i && (cfg_idx_i == REG_POWER_WAIT) && (phase_q == PH_POWER)) begin
      cnt_d = cfg_data_i;
    end
  end

  assign res = {rej, (phase_d != PH_IDLE), nib_d, en_d, 1'b0, sel_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_high_q <= ENABLE_HIGH_RST;
      nibble_gap_q  <= NIBBLE_GAP_RST;
      clear_wait_q  <= CLEAR_WAIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_POWER_WAIT:  ;  // only reloads the countdown
        REG_ENABLE_HIGH: enable_high_q <= cfg_data_i[7:0];
        REG_NIBBLE_GAP:  nibble_gap_q  <= cfg_data_i[9:0];
        default:         clear_wait_q  <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_POWER;
      cnt_q      <= POWER_WAIT_RST;
      byte_q     <= 8'h00;
      sel_q      <= 1'b0;
      lowpend_q  <= 1'b0;
      init_idx_q <= 3'd0;
      en_q       <= 1'b0;
      nib_q      <= 4'h0;
    end else begin
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      byte_q     <= byte_d;
      sel_q      <= sel_d;
      lowpend_q  <= lowpend_d;
      init_idx_q <= init_idx_d;
      en_q       <= en_d;
      nib_q      <= nib_d;
    end
  end

  // two-entry output buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      if (m_fire) begin
        v0_q <= v1_q || s_fire;
        v1_q <= v1_q && s_fire;
      end else if (s_fire) begin
        v0_q <= 1'b1;
        v1_q <= v0_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_fire) begin
      slot0_q <= v1_q ? slot1_q : res;
      if (v1_q) begin
        slot1_q <= res;
      end
    end else if (s_fire) begin
      if (v0_q) begin
        slot1_q <= res;
      end else begin
        slot0_q <= res;
      end
    end
  end

  // a dropped request is only ever reported while busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tdata[7])
    else $error("rejected result without busy");

  // enable pin is high only in the enable-high phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_q |-> (phase_q == PH_EN_HIGH))
    else $error("enable high outside enable phase");

  // a request taken while idle starts a nibble strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (phase_q == PH_IDLE) && (action != ACT_TICK)
    |=> (phase_q == PH_EN_HIGH) && en_q && lowpend_q)
    else $error("request did not start a transfer");

  // second slot never holds data without a head entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> v0_q)
    else $error("output buffer order broken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_idx_q <= INIT_COUNT)
    else $error("init index out of range");

endmodule

@@ sim/hdnw_checker.sv @@
// Checker for the LCD nibble writer: follows both streams, predicts pin states, compares.
`timescale 1ns / 100ps

module hdnw_checker
  import hdnw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] value, [8] row, [14:9] col, [15] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // [0] rs, [1] rw, [2] en, [6:3] data, [7] busy, [8] rejected
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output logic        lcd_busy_o
);

  localparam int unsigned MAX_REPORTS = 20;
  localparam logic [7:0] WAKE_SEQ [0:5] = '{8'h33, 8'h32, 8'h28, 8'h0C, 8'h06, 8'h01};

  // same bit order as m_axis_tdata[8:0]
  typedef struct packed {
    logic       rejected;
    logic       busy;
    logic [3:0] data;
    logic       en;
    logic       rw;
    logic       rs;
  } lcd_pins_t;

  // predicted configuration
  logic [15:0] power_wait = POWER_WAIT_RST;
  logic [7:0]  en_high    = ENABLE_HIGH_RST;
  logic [9:0]  gap_len    = NIBBLE_GAP_RST;
  logic [15:0] clear_wait = CLEAR_WAIT_RST;

  // predicted state
  phase_e      phase    = PH_POWER;
  logic [15:0] count    = POWER_WAIT_RST;
  logic [7:0]  byte_q   = '0;
  logic        sel_q    = 1'b0;
  logic        low_pend = 1'b0;
  logic [2:0]  init_idx = '0;
  logic        en_q     = 1'b0;
  logic [3:0]  nib_q    = '0;

  lcd_pins_t   pins_owed[$];
  lcd_pins_t   want_pins, got_pins;
  int unsigned fails = 0;
  int unsigned owed  = 0;

  assign errors_o   = fails;
  assign pending_o  = owed;
  assign lcd_busy_o = (phase != PH_IDLE);

  function automatic void strobe_nibble(logic [3:0] nib);
    nib_q = nib;
    en_q  = 1'b1;
    count = {8'h00, en_high};
    phase = PH_EN_HIGH;
  endfunction

  function automatic void load_byte(logic [7:0] b, logic sel);
    byte_q   = b;
    sel_q    = sel;
    low_pend = 1'b1;
    strobe_nibble(b[7:4]);
  endfunction

  function automatic void finish_byte();
    if (init_idx < INIT_COUNT) begin
      init_idx++;
      if (init_idx < INIT_COUNT) begin
        load_byte(WAKE_SEQ[init_idx], 1'b0);
      end else if (clear_wait == 16'd0) begin
        phase = PH_IDLE;
      end else begin
        count = clear_wait;
        phase = PH_CLEAR;
      end
    end else begin
      phase = PH_IDLE;
    end
  endfunction

  // one time tick; a count of 0 or 1 ends the current wait
  function automatic void advance_tick();
    case (phase)
      PH_POWER: begin
        if (count <= 16'd1) begin
          init_idx = '0;
          load_byte(WAKE_SEQ[0], 1'b0);
        end else count--;
      end
      PH_EN_HIGH: begin
        if (count <= 16'd1) begin
          en_q  = 1'b0;
          count = {6'd0, gap_len};
          phase = PH_GAP;
        end else count--;
      end
      PH_GAP: begin
        if (count <= 16'd1) begin
          if (low_pend) begin
            low_pend = 1'b0;
            strobe_nibble(byte_q[3:0]);
          end else finish_byte();
        end else count--;
      end
      PH_CLEAR: begin
        if (count <= 16'd1) phase = PH_IDLE;
        else count--;
      end
      default: ;
    endcase
  endfunction

  function automatic lcd_pins_t lcd_step(action_e act, logic [7:0] val, logic row,
                                         logic [5:0] col);
    lcd_pins_t  p;
    logic       drop;
    logic [7:0] addr;
    drop = 1'b0;
    addr = {2'b00, col} + (row ? {1'b0, ROW1_BASE} : 8'h00);
    if (act == ACT_TICK) advance_tick();
    else if (phase != PH_IDLE) drop = 1'b1;
    else begin
      case (act)
        ACT_CMD:  load_byte(val, 1'b0);
        ACT_DATA: load_byte(val, 1'b1);
        default:  load_byte(CURSOR_CMD | addr, 1'b0);
      endcase
    end
    p.rs       = sel_q;
    p.rw       = 1'b0;
    p.en       = en_q;
    p.data     = nib_q;
    p.busy     = (phase != PH_IDLE);
    p.rejected = drop;
    return p;
  endfunction

  function automatic void apply_cfg(cfg_reg_e idx, logic [15:0] d);
    case (idx)
      REG_POWER_WAIT: begin
        power_wait = d;
        if (phase == PH_POWER) count = d;
      end
      REG_ENABLE_HIGH: en_high    = d[7:0];
      REG_NIBBLE_GAP:  gap_len    = d[9:0];
      default:         clear_wait = d;
    endcase
  endfunction

  task automatic check_field(string fname, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      fails++;
      if (fails <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_wait = POWER_WAIT_RST;
      en_high    = ENABLE_HIGH_RST;
      gap_len    = NIBBLE_GAP_RST;
      clear_wait = CLEAR_WAIT_RST;
      phase      = PH_POWER;
      count      = POWER_WAIT_RST;
      byte_q     = '0;
      sel_q      = 1'b0;
      low_pend   = 1'b0;
      init_idx   = '0;
      en_q       = 1'b0;
      nib_q      = '0;
      pins_owed.delete();
      owed       = 0;
    end else begin
      if (cfg_we_i) apply_cfg(cfg_reg_e'(cfg_idx_i), cfg_data_i);
      if (s_axis_tvalid && s_axis_tready)
        pins_owed.push_back(lcd_step(action_e'(s_axis_tuser), s_axis_tdata[7:0],
                                     s_axis_tdata[8], s_axis_tdata[14:9]));
      if (m_axis_tvalid && m_axis_tready) begin
        got_pins = lcd_pins_t'(m_axis_tdata[8:0]);
        if (pins_owed.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("%0t ns: result with nothing expected, expected none, got %0h",
                     $time, m_axis_tdata);
        end else begin
          want_pins = pins_owed.pop_front();
          check_field("pin_rs",   {3'b0, want_pins.rs},       {3'b0, got_pins.rs});
          check_field("pin_rw",   {3'b0, want_pins.rw},       {3'b0, got_pins.rw});
          check_field("pin_en",   {3'b0, want_pins.en},       {3'b0, got_pins.en});
          check_field("pin_data", want_pins.data,             got_pins.data);
          check_field("busy",     {3'b0, want_pins.busy},     {3'b0, got_pins.busy});
          check_field("rejected", {3'b0, want_pins.rejected}, {3'b0, got_pins.rejected});
        end
      end
      owed = pins_owed.size();
    end
  end

endmodule

@@ sim/hd44780_nibble_writer_top_tb.sv @@
// Testbench top for the LCD nibble writer: clock, reset, stimulus, sink stalls and verdict.
`timescale 1ns / 100ps

module hd44780_nibble_writer_top_tb;
  import hdnw_pkg::*;

  // A correct run ends well within CYCLE_LIMIT, even with the slowest sink pattern.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned RAND_PHASES = 6;
  localparam int unsigned PHASE_ITEMS = 100;

  // All block inputs start at a known value.
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;  // [7:0] value, [8] row, [14:9] col, [15] zero
  action_e     s_axis_tuser  = ACT_TICK;  // [1:0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [0] rs, [1] rw, [2] en, [6:3] data, [7] busy, [8] rejected
  logic        cfg_we_i      = 1'b0;
  cfg_reg_e    cfg_idx_i     = REG_POWER_WAIT;
  logic [15:0] cfg_data_i    = '0;

  // Checker feedback: mismatch count, results still owed, predicted LCD busy.
  int unsigned mismatches;
  int unsigned results_owed;
  logic        lcd_busy;

  int unsigned cycles     = 0;
  int unsigned burst_left = 0;
  int unsigned ready_hold = 0;
  int unsigned n_ticks = 0, n_cmds = 0, n_data = 0, n_cursor = 0, n_dropped = 0, n_cfg = 0;

  always #5 clk_i = ~clk_i;

  hd44780_nibble_writer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  hdnw_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .errors_o      (mismatches),
    .pending_o     (results_owed),
    .lcd_busy_o    (lcd_busy)
  );

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still owed", cycles, results_owed);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Sink stalls: long open stretches, solid stalls, and cycle-by-cycle chatter.
  always @(negedge clk_i) begin
    if (ready_hold == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          m_axis_tready <= 1'b1;
          ready_hold    <= $urandom_range(20, 200);
        end
        1: begin
          m_axis_tready <= 1'b0;
          ready_hold    <= $urandom_range(1, 20);
        end
        default: begin
          m_axis_tready <= 1'($urandom_range(0, 1));
          ready_hold    <= 1;
        end
      endcase
    end else begin
      ready_hold <= ready_hold - 1;
    end
  end

  // Register write, one cycle wide, with the enable dropped again before the task returns,
  // so back-to-back writes never put two assignments on the enable in one step.
  task automatic write_reg(cfg_reg_e idx, logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    @(negedge clk_i);
    n_cfg++;
  endtask

  // One input transaction. Bursts of random length with random gaps in between;
  // some bursts are long enough to give stretches with no sender idling at all.
  task automatic send_item(action_e act, logic [7:0] val, logic row, logic [5:0] col);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    // lcd_busy here is the state before this item, so a request now gets dropped
    if (act != ACT_TICK && lcd_busy) n_dropped++;
    case (act)
      ACT_TICK: n_ticks++;
      ACT_CMD:  n_cmds++;
      ACT_DATA: n_data++;
      default:  n_cursor++;
    endcase
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {1'b0, col, row, val};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
  endtask

  // Ticks carry random junk in the data fields; the block must ignore it.
  task automatic send_tick();
    send_item(ACT_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              6'($urandom_range(0, 63)));
  endtask

  task automatic send_request();
    send_item(action_e'(2'($urandom_range(1, 3))), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
  endtask

  // Tick until the predicted LCD side goes idle (finishes a byte or the init run).
  task automatic run_until_idle();
    while (lcd_busy) send_tick();
  endtask

  // Sender holds off until every owed result is out (results are registered in the
  // output buffer and leave when the sink takes them).
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(negedge clk_i);
    while (results_owed != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  initial begin
    logic [15:0] en_val, gap_val;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Power-up wait: load the maximum, then rewrite with a short value (0 acts
    // like 1) which must reload the running countdown.
    write_reg(REG_POWER_WAIT, 16'hFFFF);
    write_reg(REG_POWER_WAIT, 16'($urandom_range(0, 3)));
    write_reg(REG_ENABLE_HIGH, 16'd1);
    write_reg(REG_NIBBLE_GAP, 16'd1);
    // Only one init run per reset: the seed picks a zero or a short clear wait.
    write_reg(REG_CLEAR_WAIT,
              ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(1, 20)));

    // Requests during the power-up wait are all dropped.
    send_item(ACT_CMD,    8'hFF, 1'b1, 6'h3F);
    send_item(ACT_DATA,   8'h00, 1'b0, 6'h00);
    send_item(ACT_CURSOR, 8'h5A, 1'b1, 6'd39);
    run_until_idle();   // power wait, six init bytes, clear wait

    send_tick();        // tick while idle changes nothing
    send_item(ACT_CMD, 8'h00, 1'b0, 6'h00);
    run_until_idle();
    send_item(ACT_DATA, 8'hFF, 1'b1, 6'h3F);
    send_item(ACT_DATA, 8'h11, 1'b0, 6'h00);   // mid-transfer: dropped
    run_until_idle();
    send_item(ACT_CURSOR, 8'h00, 1'b0, 6'd0);   // first line, column 0
    run_until_idle();
    send_item(ACT_CURSOR, 8'hFF, 1'b1, 6'd39);  // second line, last column
    run_until_idle();
    send_item(ACT_CURSOR, 8'h00, 1'b1, 6'd63);  // columns past 39 go out as given
    run_until_idle();
    send_item(ACT_CURSOR, 8'h00, 1'b0, 6'd63);
    run_until_idle();
    drain();

    // Zero strobe and gap lengths behave like one tick.
    write_reg(REG_ENABLE_HIGH, 16'd0);
    write_reg(REG_NIBBLE_GAP, 16'd0);
    send_item(ACT_DATA, 8'hA5, 1'b0, 6'h2A);
    run_until_idle();
    drain();

    // Long strobe and gap; one byte here is about 150 ticks.
    write_reg(REG_ENABLE_HIGH, 16'd24);
    write_reg(REG_NIBBLE_GAP, 16'd48);
    write_reg(REG_CLEAR_WAIT, 16'hFFFF);
    write_reg(REG_POWER_WAIT, 16'd0);
    send_item(ACT_CMD, 8'hC3, 1'b1, 6'h15);
    send_item(ACT_CURSOR, 8'h00, 1'b1, 6'd7);   // dropped
    run_until_idle();

    // Random phases: new timing per phase, mostly well-formed requests issued
    // when the LCD side is idle, plus some dropped requests as noise.
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      case ($urandom_range(0, 3))
        0:       en_val = 16'd0;
        1:       en_val = 16'd1;
        default: en_val = 16'($urandom_range(2, 6));
      endcase
      case ($urandom_range(0, 3))
        0:       gap_val = 16'd0;
        1:       gap_val = 16'd1;
        default: gap_val = 16'($urandom_range(2, 8));
      endcase
      write_reg(REG_ENABLE_HIGH, en_val);
      write_reg(REG_NIBBLE_GAP, gap_val);
      write_reg(REG_POWER_WAIT, 16'($urandom_range(0, 65535)));
      write_reg(REG_CLEAR_WAIT, (p % 2 == 0) ? 16'd0 : 16'($urandom_range(0, 65535)));
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < (lcd_busy ? 8 : 80)) send_request();
        else send_tick();
      end
    end

    s_axis_tvalid <= 1'b0;
    while (results_owed != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("Covered %0d ticks, %0d commands, %0d data bytes, %0d cursor moves",
             n_ticks, n_cmds, n_data, n_cursor);
    $display("%0d requests sent while busy, %0d register writes, %0d cycles",
             n_dropped, n_cfg, cycles);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
